// File: hdl/id_allocator_with_hint_unit_defines.svh
// Assertion macros shared by the checker of the identifier allocator.
`ifndef ID_ALLOCATOR_WITH_HINT_UNIT_DEFINES_SVH
`define ID_ALLOCATOR_WITH_HINT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IDAH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IDAH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/idah_pkg.sv
// Shared types, codes and widths of the identifier allocator.
package idah_pkg;

   localparam int WORD_W       = 32;
   localparam int BIT_W        = $clog2(WORD_W);
   localparam int ID_FIELD_W   = 10;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 24;
   localparam int ID_COUNT_DEF = 1024;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SLOT  = 2'd1,
      ST_NOT_USED = 2'd2
   } status_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } find_result_type;

endpackage

// File: hdl/idah_bit_find.sv
// Finds the lowest or the highest set bit of one bitmap word.
module idah_bit_find
   import idah_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   input  logic              dir_down,
   output find_result_type   result
);

   logic [WORD_W-1:0] rev;
   logic [WORD_W-1:0] src;
   logic [WORD_W-1:0] lsb;
   logic [BIT_W-1:0]  pos;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         rev[i] = word[WORD_W-1-i];
      end
      src = dir_down ? rev : word;
      lsb = src & (~src + WORD_W'(1));
      pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (lsb[i]) begin
            pos = pos | BIT_W'(i);
         end
      end
      result.found = |word;
      result.idx   = dir_down ? (BIT_W'(WORD_W - 1) - pos) : pos;
   end

endmodule

// File: hdl/id_allocator_with_hint_unit.sv
// Top level of the identifier allocator with a next-fit hint.
// Identifiers 0 .. ID_COUNT-1 are tracked in a bitmap RAM of 32-bit words, and one
// word is read per cycle through a single registered read port. After reset the block
// clears the bitmap, one word a cycle, and holds req_tready low meanwhile. An allocate
// scans words upward from the hint and then wraps. When a release frees the highest
// identifier, the block searches for the next lower one, reading words from that
// identifier's word down to word 0. The block takes one word at a time; a finished
// result waits in the output register while the next word is accepted.
module id_allocator_with_hint_unit
   import idah_pkg::*;
#(
   parameter int ID_COUNT = ID_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,  // cmd
   input  logic [REQ_DATA_W-1:0] req_tdata,  // release_id, zero padding
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,  // status
   output logic [RSP_DATA_W-1:0] rsp_tdata   // granted_id, highest_id, zero padding
);

   localparam int ID_W      = $clog2(ID_COUNT);
   localparam int NUM_WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int ID_X_W    = WIDX_W + BIT_W;
   localparam int WCNT_W    = $clog2(NUM_WORDS + 2);
   localparam int LAST_BITS = ID_COUNT - (NUM_WORDS - 1) * WORD_W;
   localparam logic [WORD_W-1:0] ONES      = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0] LAST_MASK = ONES >> (WORD_W - LAST_BITS);
   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);
   localparam logic [ID_W:0]     HINT_TOP  = (ID_W + 1)'(ID_COUNT);

   typedef enum logic [4:0] {
      S_CLEAR     = 5'b00001,
      S_IDLE      = 5'b00010,
      S_RLS_CHECK = 5'b00100,
      S_SCAN      = 5'b01000,
      S_DONE      = 5'b10000
   } state_type;

   logic [WORD_W-1:0] mem [NUM_WORDS];

   state_type         state_ff, state_in;
   logic [ID_W:0]     hint_ff, hint_in;
   logic [ID_W-1:0]   max_ff, max_in;
   logic [ID_X_W-1:0] rid_ff, rid_in;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   granted_ff, granted_in;
   logic              dir_down_ff, dir_down_in;
   logic [BIT_W-1:0]  first_bit_ff, first_bit_in;
   logic [WIDX_W-1:0] issue_word_ff, issue_word_in;
   logic [WCNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [WCNT_W-1:0] limit_ff, limit_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_first_ff, rd_first_in;
   logic              rd_last_ff, rd_last_in;
   logic [WIDX_W-1:0] rd_word_ff, rd_word_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ID_FIELD_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [ID_FIELD_W-1:0] rsp_highest_ff, rsp_highest_in;

   logic              wr_en;
   logic [WIDX_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WIDX_W-1:0] rd_addr;

   logic [ID_FIELD_W-1:0] req_rid;
   logic [ID_X_W-1:0]     req_rid_x;
   logic                  rid_in_range;
   logic [ID_X_W-1:0]     hint_start_x;
   logic [ID_X_W-1:0]     max_x;
   logic [ID_W-1:0]       rid_id;
   logic [ID_W-1:0]       found_id;
   logic [WORD_W-1:0]     first_up_mask;
   logic [WORD_W-1:0]     first_dn_mask;
   logic [WORD_W-1:0]     valid_mask;
   logic [WORD_W-1:0]     cand;
   find_result_type       fr;
   logic                  issue;

   assign req_rid      = req_tdata[ID_FIELD_W-1:0];
   assign req_rid_x    = ID_X_W'(req_rid);
   assign rid_in_range = ({{(32 - ID_FIELD_W){1'b0}}, req_rid} < 32'(ID_COUNT));
   assign hint_start_x = (hint_ff == HINT_TOP) ? '0 : ID_X_W'(hint_ff);
   assign max_x        = ID_X_W'(max_ff);
   assign rid_id       = ID_W'(rid_ff);

   assign first_up_mask = ONES << first_bit_ff;
   assign first_dn_mask = ONES >> (BIT_W'(WORD_W - 1) - first_bit_ff);
   assign valid_mask    = (rd_word_ff == LAST_WORD) ? LAST_MASK : ONES;
   assign cand = dir_down_ff ? (rd_data_ff & (rd_first_ff ? first_dn_mask : ONES))
                             : (~rd_data_ff & valid_mask & (rd_first_ff ? first_up_mask : ONES));

   idah_bit_find u_find (
      .word     (cand),
      .dir_down (dir_down_ff),
      .result   (fr)
   );

   assign found_id = ID_W'({rd_word_ff, fr.idx});
   assign issue    = (issue_cnt_ff < limit_ff);
   assign rd_addr  = (state_ff == S_IDLE) ? req_rid_x[ID_X_W-1:BIT_W] : issue_word_ff;

   always_comb begin
      state_in       = state_ff;
      hint_in        = hint_ff;
      max_in         = max_ff;
      rid_in         = rid_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      dir_down_in    = dir_down_ff;
      first_bit_in   = first_bit_ff;
      issue_word_in  = issue_word_ff;
      issue_cnt_in   = issue_cnt_ff;
      limit_in       = limit_ff;
      rd_vld_in      = 1'b0;
      rd_first_in    = rd_first_ff;
      rd_last_in     = rd_last_ff;
      rd_word_in     = rd_word_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_highest_in = rsp_highest_ff;
      wr_en          = 1'b0;
      wr_addr        = issue_word_ff;
      wr_data        = '0;

      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en         = 1'b1;
            issue_word_in = issue_word_ff + WIDX_W'(1);
            if (issue_word_ff == LAST_WORD) begin
               issue_word_in = '0;
               state_in      = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               status_in  = ST_OK;
               granted_in = '0;
               if (req_tuser == CMD_ALLOC) begin
                  dir_down_in   = 1'b0;
                  issue_word_in = hint_start_x[ID_X_W-1:BIT_W];
                  first_bit_in  = hint_start_x[BIT_W-1:0];
                  issue_cnt_in  = '0;
                  limit_in      = WCNT_W'(NUM_WORDS + 1);
                  state_in      = S_SCAN;
               end else if (rid_in_range) begin
                  rid_in   = req_rid_x;
                  state_in = S_RLS_CHECK;
               end else begin
                  status_in = ST_NOT_USED;
                  state_in  = S_DONE;
               end
            end
         end
         S_RLS_CHECK: begin
            if (!rd_data_ff[rid_ff[BIT_W-1:0]]) begin
               status_in = ST_NOT_USED;
               state_in  = S_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = rid_ff[ID_X_W-1:BIT_W];
               wr_data = rd_data_ff & ~(WORD_W'(1) << rid_ff[BIT_W-1:0]);
               if ((ID_W + 1)'(rid_id) < hint_ff) begin
                  hint_in = (ID_W + 1)'(rid_id);
               end
               if (rid_id == max_ff) begin
                  dir_down_in   = 1'b1;
                  issue_word_in = max_x[ID_X_W-1:BIT_W];
                  first_bit_in  = max_x[BIT_W-1:0];
                  issue_cnt_in  = '0;
                  limit_in      = WCNT_W'(max_x[ID_X_W-1:BIT_W]) + WCNT_W'(1);
                  state_in      = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (rd_vld_ff && fr.found) begin
               state_in = S_DONE;
               if (dir_down_ff) begin
                  max_in = found_id;
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = rd_word_ff;
                  wr_data    = rd_data_ff | (WORD_W'(1) << fr.idx);
                  hint_in    = (ID_W + 1)'(found_id) + (ID_W + 1)'(1);
                  granted_in = found_id;
                  if (found_id >= max_ff) begin
                     max_in = found_id;
                  end
               end
            end else if (rd_vld_ff && rd_last_ff) begin
               state_in = S_DONE;
               if (dir_down_ff) begin
                  max_in = '0;
               end else begin
                  status_in = ST_NO_SLOT;
               end
            end else if (issue) begin
               rd_vld_in    = 1'b1;
               rd_first_in  = (issue_cnt_ff == '0);
               rd_last_in   = (issue_cnt_ff == limit_ff - WCNT_W'(1));
               rd_word_in   = issue_word_ff;
               issue_cnt_in = issue_cnt_ff + WCNT_W'(1);
               if (dir_down_ff) begin
                  issue_word_in = issue_word_ff - WIDX_W'(1);
               end else if (issue_word_ff == LAST_WORD) begin
                  issue_word_in = '0;
               end else begin
                  issue_word_in = issue_word_ff + WIDX_W'(1);
               end
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in  = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = ID_FIELD_W'(granted_ff);
               rsp_highest_in = ID_FIELD_W'(max_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         hint_ff       <= '0;
         max_ff        <= '0;
         issue_word_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hint_ff       <= hint_in;
         max_ff        <= max_in;
         issue_word_ff <= issue_word_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rid_ff         <= rid_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      dir_down_ff    <= dir_down_in;
      first_bit_ff   <= first_bit_in;
      issue_cnt_ff   <= issue_cnt_in;
      limit_ff       <= limit_in;
      rd_first_ff    <= rd_first_in;
      rd_last_ff     <= rd_last_in;
      rd_word_ff     <= rd_word_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_highest_ff <= rsp_highest_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * ID_FIELD_W){1'b0}}, rsp_highest_ff, rsp_granted_ff};

endmodule

// File: hdl/idah_checker.sv
// Port-level checker of the identifier allocator and its bind statement.
`include "id_allocator_with_hint_unit_defines.svh"

module idah_checker
   import idah_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [1:0]            rsp_tuser,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `IDAH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `IDAH_ASSERT_IMPLY(a_fail_no_grant, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata[ID_FIELD_W-1:0] == '0)
   `IDAH_ASSERT_IMPLY(a_grant_le_max, clock, reset, rsp_tvalid, rsp_tdata[ID_FIELD_W-1:0] <= rsp_tdata[2*ID_FIELD_W-1:ID_FIELD_W])
   `IDAH_ASSERT_IMPLY(a_clear_after_reset, clock, reset, $past(reset), !req_tready)

endmodule

bind id_allocator_with_hint_unit idah_checker u_idah_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/id_allocator_with_hint_unit_test.sv
// Self-checking testbench of the identifier allocator with next-fit hint.
`timescale 1ns / 1ps

module id_allocator_with_hint_unit_test;
   import idah_pkg::*;

   localparam int ID_SPACE     = ID_COUNT_DEF;
   localparam int RANDOM_WORDS = 300;
   localparam int QUIET_FROM   = 240;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_AT     = 160;
   localparam int TAIL_CYCLES  = 48;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DIR_ROWS     = 20;

   typedef struct packed {
      status_type                status;
      logic [ID_FIELD_W-1:0] granted;
      logic [ID_FIELD_W-1:0] highest;
   } outcome_type;

   typedef struct {
      cmd_type               op;
      logic [ID_FIELD_W-1:0] id;
      int                    reps;
      bit                    typed;
      outcome_type           want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic                  req_tuser;   // cmd
   logic [REQ_DATA_W-1:0] req_tdata;   // release_id, zero padding
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [1:0]            rsp_tuser;   // status
   logic [RSP_DATA_W-1:0] rsp_tdata;   // granted_id, highest_id, zero padding

   logic [ID_SPACE-1:0]   id_used;
   int                    next_hint;
   logic [ID_FIELD_W-1:0] top_id;
   outcome_type           outcome_q[$];
   int                    error_count = 0;
   int                    idle_cycles = 0;
   bit                    quiet = 1'b0;
   bit                    start_hold = 1'b0;
   bit                    hold_rsp = 1'b0;

   stim_row_type directed_rows [DIR_ROWS] = '{
      '{CMD_ALLOC,   10'd0,    1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_ALLOC,   10'd0,    1,    1'b1, '{ST_OK,       10'd1,    10'd1}},
      '{CMD_RELEASE, 10'd1,    1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd1,    1,    1'b1, '{ST_NOT_USED, 10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd1023, 1,    1'b1, '{ST_NOT_USED, 10'd0,    10'd0}},
      '{CMD_RELEASE, 10'h2AA,  1,    1'b1, '{ST_NOT_USED, 10'd0,    10'd0}},
      '{CMD_RELEASE, 10'h155,  1,    1'b1, '{ST_NOT_USED, 10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd0,    1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd0,    1,    1'b1, '{ST_NOT_USED, 10'd0,    10'd0}},
      '{CMD_ALLOC,   10'd1023, 1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_ALLOC,   10'd0,    40,   1'b0, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd40,   1,    1'b1, '{ST_OK,       10'd0,    10'd39}},
      '{CMD_RELEASE, 10'd5,    1,    1'b1, '{ST_OK,       10'd0,    10'd39}},
      '{CMD_ALLOC,   10'd0,    1,    1'b1, '{ST_OK,       10'd5,    10'd39}},
      '{CMD_ALLOC,   10'd0,    1,    1'b1, '{ST_OK,       10'd40,   10'd40}},
      '{CMD_RELEASE, 10'd1,    39,   1'b0, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd40,   1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd0,    1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_ALLOC,   10'd0,    1,    1'b1, '{ST_OK,       10'd0,    10'd0}},
      '{CMD_RELEASE, 10'd0,    1,    1'b1, '{ST_OK,       10'd0,    10'd0}}
   };

   id_allocator_with_hint_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic outcome_type compute_outcome(cmd_type op, logic [ID_FIELD_W-1:0] rid);
      outcome_type res;
      bit          found;
      int          pick;
      int          i;
      res = '{ST_OK, '0, '0};
      found = 1'b0;
      pick = 0;
      if (op == CMD_ALLOC) begin
         for (i = next_hint; i < ID_SPACE; i++) begin
            if (!found && !id_used[i]) begin
               found = 1'b1;
               pick = i;
            end
         end
         for (i = 0; i < next_hint; i++) begin
            if (!found && !id_used[i]) begin
               found = 1'b1;
               pick = i;
            end
         end
         if (found) begin
            id_used[pick] = 1'b1;
            next_hint = pick + 1;
            if (pick >= int'(top_id)) top_id = pick[ID_FIELD_W-1:0];
            res.granted = pick[ID_FIELD_W-1:0];
         end else begin
            res.status = ST_NO_SLOT;
         end
      end else if (id_used[rid]) begin
         id_used[rid] = 1'b0;
         if (int'(rid) < next_hint) next_hint = int'(rid);
         if (rid == top_id) begin
            i = int'(top_id);
            while (i > 0 && !id_used[i]) i--;
            top_id = i[ID_FIELD_W-1:0];
         end
      end else begin
         res.status = ST_NOT_USED;
      end
      res.highest = top_id;
      return res;
   endfunction

   function automatic logic [ID_FIELD_W-1:0] pick_used_id();
      int start;
      int k;
      int j;
      start = $urandom_range(0, ID_SPACE - 1);
      for (k = 0; k < ID_SPACE; k++) begin
         j = (start + k) % ID_SPACE;
         if (id_used[j]) return j[ID_FIELD_W-1:0];
      end
      return start[ID_FIELD_W-1:0];
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic issue_word(cmd_type op, logic [ID_FIELD_W-1:0] id, bit typed,
                             outcome_type want);
      outcome_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - ID_FIELD_W){1'b0}}, id};
      do @(posedge clock); while (!req_tready);
      predicted = compute_outcome(op, id);
      outcome_q.push_back(typed ? want : predicted);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   initial begin
      int       r;
      int       k;
      int       n;
      int       alloc_pct;
      cmd_type  op;
      logic [ID_FIELD_W-1:0] id;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      id_used    = '0;
      next_hint  = 0;
      top_id     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIR_ROWS; r++) begin
         for (k = 0; k < directed_rows[r].reps; k++) begin
            issue_word(directed_rows[r].op, directed_rows[r].id + k[ID_FIELD_W-1:0],
                       directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n >= QUIET_FROM) quiet = 1'b1;
         if (n == HOLD_AT) start_hold = 1'b1;
         if (n == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outcome_q.size() != 0);
         end
         case (n / 100)
            0:       alloc_pct = 60;
            1:       alloc_pct = 85;
            2:       alloc_pct = 35;
            default: alloc_pct = 55;
         endcase
         id = ID_FIELD_W'($urandom_range(0, ID_SPACE - 1));
         if ($urandom_range(0, 99) < alloc_pct) begin
            op = CMD_ALLOC;
         end else begin
            op = CMD_RELEASE;
            r = $urandom_range(0, 99);
            if (r >= 35) id = pick_used_id();
            else if (r >= 15) id = top_id;
         end
         issue_word(op, id, 1'b0, '{ST_OK, '0, '0});
      end

      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && outcome_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      wait (start_hold);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int          stall_left;
      outcome_type want;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("unexpected word", int'(rsp_tuser), -1);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", int'(rsp_tuser), int'(want.status));
               if (rsp_tdata[ID_FIELD_W-1:0] != want.granted)
                  report_mismatch("granted_id", int'(rsp_tdata[ID_FIELD_W-1:0]),
                                  int'(want.granted));
               if (rsp_tdata[2*ID_FIELD_W-1:ID_FIELD_W] != want.highest)
                  report_mismatch("highest_id", int'(rsp_tdata[2*ID_FIELD_W-1:ID_FIELD_W]),
                                  int'(want.highest));
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
